// File: hdl/tcce_pkg.sv
package tcce_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLS;

  // Field widths fixed by the port list
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CHR_W  = 8;
  localparam int CELL_W = 16;

  // Cell address that may run past the last cell (start + 7)
  localparam int CA_W   = $clog2(CELLS + 8);
  // Sweep pointer, holds CELLS itself
  localparam int PTR_W  = $clog2(CELLS + 1);
  localparam int RAM_AW = $clog2(CELLS);

  localparam logic [2:0] FN_PUT   = 3'd0;
  localparam logic [2:0] FN_HEX   = 3'd1;
  localparam logic [2:0] FN_BIN   = 3'd2;
  localparam logic [2:0] FN_DEC   = 3'd3;
  localparam logic [2:0] FN_CLEAR = 3'd4;
  localparam logic [2:0] FN_READ  = 3'd5;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_PUT, S_LINE, S_HEX_LO, S_HEX_HI, S_BCD,
    S_DIGITS, S_ADV8, S_SCROLL_RD, S_SCROLL, S_BLANK, S_CLEAR, S_READ, S_RESP
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_CHAR, WR_HEX_LO, WR_HEX_HI, WR_DIGIT, WR_ZERO, WR_COPY
  } wr_t;

  typedef enum logic [1:0] {ADV_NONE, ADV_ONE, ADV_EIGHT, ADV_LINE} adv_t;

  typedef enum logic [1:0] {RD_IDX, RD_PRIME, RD_NEXT} rd_t;

  typedef struct packed {
    logic load;
    logic resp;
    logic cur_clr;
    logic ptr_clr;
    logic ptr_inc;
    logic k_inc;
    logic bcd_step;
    wr_t  wr;
    adv_t adv;
    rd_t  rd;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       ch_zero;
    logic       ch_nl;
    logic       need_scroll;
    logic       ptr_copy_last;
    logic       ptr_last;
    logic       k_last;
    logic       bit_last;
    logic       out_free;
  } status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + {4'h0, nib};
    else return CH_A + {4'h0, nib} - 8'd10;
  endfunction

endpackage

// File: hdl/tcce_ram.sv
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tcce_ctrl.sv
module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   ret_hex, ret_hex_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      ret_hex <= 1'b0;
    end else begin
      state   <= state_next;
      ret_hex <= ret_hex_next;
    end
  end

  always_comb begin
    state_next   = state;
    ret_hex_next = ret_hex;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.wr       = WR_NONE;
    cmd.adv      = ADV_NONE;
    cmd.rd       = RD_IDX;
    case (state)
      S_INIT: begin
        cmd.wr      = WR_ZERO;
        cmd.ptr_inc = 1'b1;
        if (st.ptr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.func)
          FN_PUT: begin
            if (st.ch_zero) state_next = S_RESP;
            else if (st.ch_nl) state_next = S_LINE;
            else state_next = S_PUT;
          end
          FN_HEX: state_next = S_HEX_LO;
          FN_BIN: state_next = S_DIGITS;
          FN_DEC: state_next = S_BCD;
          FN_CLEAR: begin
            cmd.cur_clr = 1'b1;
            cmd.ptr_clr = 1'b1;
            state_next  = S_CLEAR;
          end
          FN_READ: state_next = S_READ;
          default: state_next = S_RESP;
        endcase
      end
      S_LINE: begin
        cmd.adv      = ADV_LINE;
        ret_hex_next = 1'b0;
        state_next   = st.need_scroll ? S_SCROLL_RD : S_RESP;
      end
      S_PUT: begin
        cmd.wr       = WR_CHAR;
        cmd.adv      = ADV_ONE;
        ret_hex_next = 1'b0;
        state_next   = st.need_scroll ? S_SCROLL_RD : S_RESP;
      end
      S_HEX_LO: begin
        cmd.wr       = WR_HEX_LO;
        cmd.adv      = ADV_ONE;
        ret_hex_next = 1'b1;
        state_next   = st.need_scroll ? S_SCROLL_RD : S_HEX_HI;
      end
      S_HEX_HI: begin
        cmd.wr       = WR_HEX_HI;
        cmd.adv      = ADV_ONE;
        ret_hex_next = 1'b0;
        state_next   = st.need_scroll ? S_SCROLL_RD : S_RESP;
      end
      S_BCD: begin
        cmd.bcd_step = 1'b1;
        if (st.bit_last) state_next = S_DIGITS;
      end
      S_DIGITS: begin
        cmd.wr    = WR_DIGIT;
        cmd.k_inc = 1'b1;
        if (st.k_last) state_next = S_ADV8;
      end
      S_ADV8: begin
        cmd.adv      = ADV_EIGHT;
        ret_hex_next = 1'b0;
        state_next   = st.need_scroll ? S_SCROLL_RD : S_RESP;
      end
      S_SCROLL_RD: begin
        cmd.rd      = RD_PRIME;
        cmd.ptr_clr = 1'b1;
        state_next  = S_SCROLL;
      end
      S_SCROLL: begin
        cmd.wr      = WR_COPY;
        cmd.rd      = RD_NEXT;
        cmd.ptr_inc = 1'b1;
        if (st.ptr_copy_last) state_next = S_BLANK;
      end
      S_BLANK: begin
        cmd.wr      = WR_ZERO;
        cmd.ptr_inc = 1'b1;
        if (st.ptr_last) state_next = ret_hex ? S_HEX_HI : S_RESP;
      end
      S_CLEAR: begin
        cmd.wr      = WR_ZERO;
        cmd.ptr_inc = 1'b1;
        if (st.ptr_last) state_next = S_RESP;
      end
      S_READ: state_next = S_RESP;
      S_RESP: begin
        cmd.resp = 1'b1;
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("ready outside idle");
  a_load_dispatch: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DISPATCH)
    else $error("load did not dispatch");
  a_scroll_seq: assert property (@(posedge clk) disable iff (rst)
    state == S_SCROLL_RD |=> state == S_SCROLL)
    else $error("scroll prime not followed by copy");
`endif

endmodule

// File: hdl/tcce_dpath.sv
module tcce_dpath
  import tcce_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          st,
  input  logic [2:0]       func,
  input  logic [31:0]      value,
  input  logic [7:0]       color,
  input  logic [IDX_W-1:0] cell_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CHR_W-1:0] read_char,
  output logic [CHR_W-1:0] read_attr,
  output logic [COL_W-1:0] cursor_col,
  output logic [ROW_W-1:0] cursor_row
);

  logic [2:0]        func_r;
  logic [31:0]       value_r;
  logic [7:0]        color_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CA_W-1:0]   start_r;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [PTR_W-1:0]  ptr;
  logic [2:0]        k;
  logic [4:0]        bitcnt;
  logic [31:0]       bcd;
  logic [31:0]       sh;

  logic [COL_W:0]    col_sum;
  logic              wrap;
  logic              row_last;
  logic [CA_W-1:0]   cur_start;
  logic [CA_W-1:0]   wa;
  logic              we;
  logic [CELL_W-1:0] wdata;
  logic [PTR_W-1:0]  ra;
  logic [CELL_W-1:0] rdata;
  logic [7:0]        dig_char;
  logic [31:0]       bcd_adj;
  logic              idx_ok;

  assign cur_start = CA_W'(row) * CA_W'(COLS) + CA_W'(col);
  assign col_sum   = {1'b0, col} + ((cmd.adv == ADV_EIGHT) ? (COL_W+1)'(8) : (COL_W+1)'(1));
  assign wrap      = (cmd.adv == ADV_LINE) ||
                     ((cmd.adv != ADV_NONE) && (col_sum >= (COL_W+1)'(COLS)));
  assign row_last  = (row == ROW_W'(ROWS - 1));

  // Digit k of eight, most significant first
  always_comb begin
    if (func_r == FN_BIN) dig_char = CH_ZERO + {7'h0, value_r[3'd7 - k]};
    else dig_char = CH_ZERO + {4'h0, bcd[{3'd7 - k, 2'b00} +: 4]};
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    wa    = start_r;
    wdata = '0;
    case (cmd.wr)
      WR_CHAR:   wdata = {color_r, value_r[7:0]};
      WR_HEX_LO: begin
        wa    = start_r + CA_W'(1);
        wdata = {color_r, hex_char(value_r[3:0])};
      end
      WR_HEX_HI: wdata = {color_r, hex_char(value_r[7:4])};
      WR_DIGIT: begin
        wa    = start_r + CA_W'(k);
        wdata = {color_r, dig_char};
      end
      WR_ZERO:   wa = CA_W'(ptr);
      WR_COPY: begin
        wa    = CA_W'(ptr);
        wdata = rdata;
      end
      default:   wa = start_r;
    endcase
  end

  // Drop writes past the last cell
  assign we = (cmd.wr != WR_NONE) && (wa < CA_W'(CELLS));

  always_comb begin
    case (cmd.rd)
      RD_PRIME: ra = PTR_W'(COLS);
      RD_NEXT:  ra = ptr + PTR_W'(COLS + 1);
      default:  ra = PTR_W'(idx_r);
    endcase
  end

  tcce_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (RAM_AW'(wa)),
    .wdata (wdata),
    .raddr (RAM_AW'(ra)),
    .rdata (rdata)
  );

  assign idx_ok = ({21'h0, idx_r} < 32'(CELLS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func;
      value_r <= value;
      color_r <= color;
      idx_r   <= cell_index;
      start_r <= cur_start;
      sh      <= value;
      bcd     <= '0;
    end else if (cmd.bcd_step) begin
      bcd <= {bcd_adj[30:0], sh[31]};
      sh  <= {sh[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      ptr       <= '0;
      k         <= '0;
      bitcnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cur_clr) begin
        col <= '0;
        row <= '0;
      end else if (cmd.adv != ADV_NONE) begin
        if (wrap) begin
          col <= '0;
          if (!row_last) row <= row + ROW_W'(1);
        end else begin
          col <= col_sum[COL_W-1:0];
        end
      end
      if (cmd.ptr_clr) ptr <= '0;
      else if (cmd.ptr_inc) ptr <= ptr + PTR_W'(1);
      if (cmd.load) begin
        k      <= '0;
        bitcnt <= '0;
      end else begin
        if (cmd.k_inc) k <= k + 3'd1;
        if (cmd.bcd_step) bitcnt <= bitcnt + 5'd1;
      end
      if (cmd.resp && st.out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp && st.out_free) begin
      if (func_r == FN_READ && idx_ok) begin
        read_char <= rdata[7:0];
        read_attr <= rdata[15:8];
      end else begin
        read_char <= '0;
        read_attr <= '0;
      end
      cursor_col <= col;
      cursor_row <= row;
    end
  end

  always_comb begin
    st.func          = func_r;
    st.ch_zero       = (value_r[7:0] == CH_NUL);
    st.ch_nl         = (value_r[7:0] == CH_LF) || (value_r[7:0] == CH_CR);
    st.need_scroll   = wrap && row_last;
    st.ptr_copy_last = (ptr == PTR_W'(COPY_N - 1));
    st.ptr_last      = (ptr == PTR_W'(CELLS - 1));
    st.k_last        = (k == 3'd7);
    st.bit_last      = (bitcnt == 5'd31);
    st.out_free      = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col < COL_W'(COLS))
    else $error("cursor column out of range");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row < ROW_W'(ROWS))
    else $error("cursor row out of range");
  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr == WR_ZERO || cmd.wr == WR_COPY) |-> ptr < PTR_W'(CELLS))
    else $error("sweep pointer past the screen");
`endif

endmodule

// File: hdl/text_console_cursor_engine_core.sv
// Text console engine: a COLS x ROWS screen of character/attribute cells
// plus a cursor, driven by one command transaction at a time.
// Input channel (in_valid/in_ready): func, value, color, cell_index.
// Output channel (out_valid/out_ready): one result transaction per
// command with read_char/read_attr (cell contents for a read of a cell on the screen, else zero)
// and the cursor position after the command.
// A command passes through dispatch and then, for a put, hex, binary or
// decimal command, its cell writes; a decimal value goes one bit a cycle
// through the BCD shifter and its digits are then written one cell per
// cycle, and a clear zeroes every cell of the screen.
// A scroll uses the one screen store port pair to copy one cell per
// cycle and then blanks the bottom row.
// One command is in flight at a time; in_ready rises again once the result
// is loaded into the output register, so a new command may be taken while
// that result still waits for out_ready. A stalled receiver holds the
// result and, once the next command is done, the engine waits for it.
// After reset the engine sweeps the whole store to zero with in_ready
// low, and the cursor starts at row 0, column 0.
module text_console_cursor_engine_core
  import tcce_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       func,
  input  logic [31:0]      value,
  input  logic [7:0]       color,
  input  logic [IDX_W-1:0] cell_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CHR_W-1:0] read_char,
  output logic [CHR_W-1:0] read_attr,
  output logic [COL_W-1:0] cursor_col,
  output logic [ROW_W-1:0] cursor_row
);

  cmd_t    cmd;
  status_t st;

  // Sequence each command over the datapath
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Cursor, digit generation, screen store and output register
  tcce_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .func       (func),
    .value      (value),
    .color      (color),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_char  (read_char),
    .read_attr  (read_attr),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
  );

endmodule

// File: dv/text_console_cursor_engine_core_test.sv
module text_console_cursor_engine_core_test;
  import tcce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Character code for a set bit in the binary dump; not in the package
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam int RAND_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int IDLE_PCT = 33;

  // One result transaction: cell read-back plus cursor after the command
  typedef struct {
    logic [CHR_W-1:0] rchar;
    logic [CHR_W-1:0] rattr;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } console_resp_t;

  // One row of the directed table; when known is set the result is typed in
  typedef struct {
    logic [2:0]       fn;
    logic [31:0]      val;
    logic [7:0]       attr;
    logic [IDX_W-1:0] idx;
    bit               known;
    console_resp_t    resp;
  } console_cmd_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [2:0]       func = FN_PUT;
  logic [31:0]      value = '0;
  logic [7:0]       color = '0;
  logic [IDX_W-1:0] cell_index = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CHR_W-1:0] read_char;
  logic [CHR_W-1:0] read_attr;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;

  text_console_cursor_engine_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .value      (value),
    .color      (color),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_char  (read_char),
    .read_attr  (read_attr),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Shadow copy of the screen and cursor
  logic [15:0] shadow_cells [CELLS];
  int unsigned cur_col;
  int unsigned cur_row;

  console_resp_t pending_resp[$];
  int mismatches;
  int checked;
  int scrolls;
  int cycles;
  bit no_idle;

  // Shift every row up one and blank the bottom row
  task automatic scroll_screen();
    for (int i = 0; i < COPY_N; i++) shadow_cells[i] = shadow_cells[i + COLS];
    for (int i = COPY_N; i < CELLS; i++) shadow_cells[i] = '0;
    scrolls++;
  endtask

  task automatic new_line();
    cur_col = 0;
    if (cur_row < ROWS - 1) cur_row++;
    else scroll_screen();
  endtask

  task automatic advance_col(int unsigned n);
    cur_col += n;
    if (cur_col >= COLS) new_line();
  endtask

  // Drop anything past the last cell
  task automatic write_cell(int unsigned addr, logic [7:0] ch, logic [7:0] attr);
    if (addr < CELLS) shadow_cells[addr] = {attr, ch};
  endtask

  // Apply one command to the shadow screen and return the result it gives
  task automatic apply_command(input console_cmd_t c, output console_resp_t r);
    int unsigned start;
    logic [7:0] ch;
    logic [3:0] nib;
    logic [31:0] dec;
    start = cur_row * COLS + cur_col;
    ch = c.val[7:0];
    dec = c.val;
    r.rchar = '0;
    r.rattr = '0;
    case (c.fn)
      FN_PUT: begin
        if (ch == CH_LF || ch == CH_CR) begin
          new_line();
        end else if (ch != CH_NUL) begin
          write_cell(start, ch, c.attr);
          advance_col(1);
        end
      end
      FN_HEX: begin
        // Low digit lands one cell to the right, then the high digit
        for (int k = 1; k >= 0; k--) begin
          nib = ch[3:0];
          write_cell(start + k, (nib < 10) ? CH_ZERO + nib : CH_A + nib - 8'd10,
                     c.attr);
          ch = ch >> 4;
          advance_col(1);
        end
      end
      FN_BIN: begin
        for (int k = 7; k >= 0; k--) begin
          write_cell(start + k, ch[0] ? CH_ONE : CH_ZERO, c.attr);
          ch = ch >> 1;
        end
        advance_col(8);
      end
      FN_DEC: begin
        for (int k = 7; k >= 0; k--) begin
          write_cell(start + k, CH_ZERO + 8'(dec % 10), c.attr);
          dec = dec / 10;
        end
        advance_col(8);
      end
      FN_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
        cur_col = 0;
        cur_row = 0;
      end
      FN_READ: begin
        if (c.idx < CELLS) begin
          r.rchar = shadow_cells[c.idx][7:0];
          r.rattr = shadow_cells[c.idx][15:8];
        end
      end
      default: begin
      end
    endcase
    r.col = COL_W'(cur_col);
    r.row = ROW_W'(cur_row);
  endtask

  // Hold the command until the engine takes it, with random gaps in front
  task automatic issue_command(input console_cmd_t c);
    console_resp_t r;
    bit took;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= c.fn;
    value      <= c.val;
    color      <= c.attr;
    cell_index <= c.idx;
    // Sample ready mid-cycle, where it is stable up to the next rising edge
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    apply_command(c, r);
    pending_resp.push_back(c.known ? c.resp : r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_resp.size() != 0);
  endtask

  function automatic console_resp_t typed(logic [7:0] rc, logic [7:0] ra,
                                          int unsigned col, int unsigned row);
    typed.rchar = rc;
    typed.rattr = ra;
    typed.col = COL_W'(col);
    typed.row = ROW_W'(row);
  endfunction

  // Receiver: stall at random except during the quiet stretch
  always @(posedge clk) begin
    out_ready <= !rst && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    console_resp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = pending_resp.pop_front();
        checked++;
        if (read_char !== e.rchar || read_attr !== e.rattr ||
            cursor_col !== e.col || cursor_row !== e.row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp ch=%h at=%h c=%0d r=%0d got ch=%h at=%h c=%0d r=%0d",
                     checked, e.rchar, e.rattr, e.col, e.row,
                     read_char, read_attr, cursor_col, cursor_row);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    console_cmd_t table_rows[$];
    console_cmd_t c;
    int rr;
    int nl_pct;

    for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
    cur_col = 0;
    cur_row = 0;
    mismatches = 0;
    checked = 0;
    scrolls = 0;
    cycles = 0;
    no_idle = 0;

    // Directed rows: fn, value, color, index, typed?, result
    table_rows = '{
      '{FN_READ, 32'h0, 8'h00, 11'd0, 1'b1, typed(0, 0, 0, 0)},
      '{FN_READ, 32'h0, 8'h00, 11'd2047, 1'b1, typed(0, 0, 0, 0)},
      '{FN_PUT, 32'hFFFF_FF00, 8'hFF, 11'd0, 1'b1, typed(0, 0, 0, 0)},
      '{FN_PUT, 32'h41, 8'hFF, 11'd0, 1'b1, typed(0, 0, 1, 0)},
      '{FN_READ, 32'h0, 8'h00, 11'd0, 1'b1, typed(CH_A, 8'hFF, 1, 0)},
      '{FN_PUT, 32'h0A, 8'h00, 11'd0, 1'b1, typed(0, 0, 0, 1)},
      '{FN_PUT, 32'h0D, 8'h00, 11'd0, 1'b1, typed(0, 0, 0, 2)},
      '{FN_HEX, 32'hAB, 8'h1E, 11'd0, 1'b0, typed(0, 0, 0, 0)},
      '{FN_HEX, 32'h00, 8'h00, 11'd0, 1'b0, typed(0, 0, 0, 0)},
      '{FN_HEX, 32'hFF, 8'h80, 11'd0, 1'b0, typed(0, 0, 0, 0)},
      '{FN_BIN, 32'h55, 8'h07, 11'd0, 1'b0, typed(0, 0, 0, 0)},
      '{FN_BIN, 32'hFFFF_FF00, 8'h70, 11'd0, 1'b0, typed(0, 0, 0, 0)},
      '{FN_DEC, 32'hFFFF_FFFF, 8'h0F, 11'd0, 1'b0, typed(0, 0, 0, 0)},
      '{FN_DEC, 32'h0, 8'h01, 11'd0, 1'b0, typed(0, 0, 0, 0)},
      '{FN_DEC, 32'd12345678, 8'h02, 11'd0, 1'b0, typed(0, 0, 0, 0)},
      '{FN_SPARE6, 32'hDEAD_BEEF, 8'hAA, 11'd5, 1'b0, typed(0, 0, 0, 0)},
      '{FN_SPARE7, 32'h1234_5678, 8'h55, 11'd7, 1'b0, typed(0, 0, 0, 0)},
      '{FN_READ, 32'h0, 8'h00, 11'd160, 1'b0, typed(0, 0, 0, 0)},
      '{FN_READ, 32'h0, 8'h00, 11'd161, 1'b0, typed(0, 0, 0, 0)},
      '{FN_READ, 32'h0, 8'h00, 11'd1999, 1'b0, typed(0, 0, 0, 0)},
      '{FN_READ, 32'h0, 8'h00, 11'd2000, 1'b1, typed(0, 0, 46, 2)},
      '{FN_CLEAR, 32'h0, 8'h00, 11'd0, 1'b1, typed(0, 0, 0, 0)},
      '{FN_READ, 32'h0, 8'h00, 11'd160, 1'b1, typed(0, 0, 0, 0)}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) issue_command(table_rows[i]);
    // Hold off input until the directed results are all back
    drain_results();

    // Random part: in blocks of 100, one block in three is a newline-heavy mix,
    // which walks the cursor to the bottom and scrolls; the rest are cell-heavy
    for (int n = 0; n < RAND_ITEMS; n++) begin
      nl_pct = ((n / 100) % 3 == 1) ? 30 : 4;
      no_idle = (n >= 700 && n < 1000);
      c.val = $urandom();
      c.attr = 8'($urandom());
      c.idx = IDX_W'($urandom_range(2047));
      c.known = 1'b0;
      c.resp = typed(0, 0, 0, 0);
      rr = $urandom_range(99);
      if (rr < nl_pct) begin
        c.fn = FN_PUT;
        c.val[7:0] = ($urandom_range(1)) ? CH_LF : CH_CR;
      end else if (rr < 45) begin
        c.fn = FN_PUT;
        if ($urandom_range(19) == 0) c.val[7:0] = CH_NUL;
      end else if (rr < 55) c.fn = FN_HEX;
      else if (rr < 64) c.fn = FN_BIN;
      else if (rr < 71) c.fn = FN_DEC;
      else if (rr < 72) c.fn = FN_CLEAR;
      else if (rr < 74) c.fn = ($urandom_range(1)) ? FN_SPARE6 : FN_SPARE7;
      else begin
        c.fn = FN_READ;
        // Read mostly around the cursor where cells were just written
        if ($urandom_range(1))
          c.idx = IDX_W'((cur_row * COLS + cur_col + CELLS - $urandom_range(15)) % CELLS);
      end
      issue_command(c);
      if (n == 800) drain_results();
    end

    drain_results();
    repeat (100) @(posedge clk);

    $display("checked %0d results over %0d random and %0d directed commands,",
             checked, RAND_ITEMS, table_rows.size());
    $display("%0d scrolls, %0d mismatches", scrolls, mismatches);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
